// File: sv/fpr_pkg.sv
package fpr_pkg;

    localparam int MAX_PAGES    = 16;
    localparam int MAX_FRAMES   = 8;
    localparam int TOTAL_FRAMES = 512;

    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int FRAME_W = $clog2(TOTAL_FRAMES);
    localparam int FIU_W   = 4;
    localparam int CFG_W   = FRAME_W;
    localparam int IDX_W   = 1;

    localparam logic [FIU_W-1:0]   FRAMES_IN_USE_RESET = FIU_W'(3);
    localparam logic [FRAME_W-1:0] FIRST_FRAME_RESET   = FRAME_W'(2);

    localparam logic [IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [IDX_W-1:0] REG_FIRST_FRAME   = 1'b1;

    typedef struct packed {
        logic accept;
        logic hit_out;
        logic free_commit;
        logic evict_read;
        logic evict_commit;
    } t_cmd;

    typedef struct packed {
        logic resident;
        logic room;
        logic out_free;
    } t_sts;

endpackage

// File: sv/fpr_ctrl.sv
module fpr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fpr_pkg::t_sts i_sts,
    output fpr_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_EVICT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.resident) begin
                    if (i_sts.out_free) begin
                        o_cmd.hit_out = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.room) begin
                    if (i_sts.out_free) begin
                        o_cmd.free_commit = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.evict_read = 1'b1;
                    n_state          = S_EVICT;
                end
            end
            S_EVICT: begin
                if (i_sts.out_free) begin
                    o_cmd.evict_commit = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/fpr_dp.sv
module fpr_dp #(
    parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpr_pkg::t_cmd                i_cmd,
    output fpr_pkg::t_sts                o_sts,
    input  logic                         i_cfg_we,
    input  logic [fpr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [fpr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [fpr_pkg::PAGE_W-1:0]   i_page,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit,
    output logic [fpr_pkg::FRAME_W-1:0]  o_frame,
    output logic                         o_evicted,
    output logic [fpr_pkg::PAGE_W-1:0]   o_evicted_page
);

    localparam int PAGE_W  = fpr_pkg::PAGE_W;
    localparam int FRAME_W = fpr_pkg::FRAME_W;
    localparam int FIU_W   = fpr_pkg::FIU_W;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int FI_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int GW      = (CNT_W > FIU_W) ? CNT_W : FIU_W;
    localparam int SW      = CNT_W + 1;

    logic [FIU_W-1:0]   r_fiu;
    logic [FRAME_W-1:0] r_first;

    logic [PAGE_W-1:0]          r_page;
    logic [PAGE_W-1:0]          r_victim;
    logic [fpr_pkg::MAX_PAGES-1:0] r_resident;
    logic [CNT_W-1:0]           r_count;
    logic [FI_W-1:0]            r_head;
    logic [FI_W-1:0]            n_head;

    logic [FRAME_W-1:0] m_pf [fpr_pkg::MAX_PAGES];
    logic [FRAME_W-1:0] r_pf_q;
    logic [PAGE_W-1:0]  m_fifo [MAX_FRAMES];
    logic [PAGE_W-1:0]  r_fifo_q;

    logic               r_o_valid;
    logic               n_o_valid;
    logic               w_load;
    logic [GW-1:0]      w_grant;
    logic [SW-1:0]      w_tail_sum;
    logic [FI_W-1:0]    w_tail;
    logic [FRAME_W:0]   w_free_sum;
    logic               w_pf_we;
    logic               w_pf_re;
    logic [PAGE_W-1:0]  w_pf_addr;
    logic [FRAME_W-1:0] w_pf_wd;
    logic               w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu   <= fpr_pkg::FRAMES_IN_USE_RESET;
            r_first <= fpr_pkg::FIRST_FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpr_pkg::REG_FRAMES_IN_USE: r_fiu   <= i_cfg_data[FIU_W-1:0];
                fpr_pkg::REG_FIRST_FRAME:   r_first <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_grant = GW'(r_fiu);
        if (r_fiu == '0) w_grant = GW'(1);
        if (w_grant > GW'(MAX_FRAMES)) w_grant = GW'(MAX_FRAMES);
    end

    assign w_tail_sum = SW'(r_head) + SW'(r_count);
    assign w_tail     = (w_tail_sum >= SW'(MAX_FRAMES))
                        ? FI_W'(w_tail_sum - SW'(MAX_FRAMES)) : FI_W'(w_tail_sum);
    assign n_head     = (r_head == FI_W'(MAX_FRAMES - 1)) ? '0 : r_head + 1'b1;
    assign w_free_sum = (FRAME_W + 1)'(r_first) + (FRAME_W + 1)'(r_count);

    assign w_push    = i_cmd.free_commit | i_cmd.evict_commit;
    assign w_pf_we   = w_push;
    assign w_pf_re   = i_cmd.accept | i_cmd.evict_read;
    assign w_pf_wd   = i_cmd.evict_commit ? r_pf_q : w_free_sum[FRAME_W-1:0];
    assign w_pf_addr = i_cmd.evict_read ? r_fifo_q : (w_pf_we ? r_page : i_page);

    always_ff @(posedge i_clk) begin
        if (w_pf_we) begin
            m_pf[w_pf_addr] <= w_pf_wd;
        end else if (w_pf_re) begin
            r_pf_q <= m_pf[w_pf_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            m_fifo[w_tail] <= r_page;
        end
        r_fifo_q <= m_fifo[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_page <= i_page;
        if (i_cmd.evict_read) r_victim <= r_fifo_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident <= '0;
            r_count    <= '0;
            r_head     <= '0;
        end else begin
            if (i_cmd.evict_read) r_resident[r_fifo_q] <= 1'b0;
            if (w_push) r_resident[r_page] <= 1'b1;
            if (i_cmd.free_commit) r_count <= r_count + 1'b1;
            if (i_cmd.evict_commit) r_head <= n_head;
        end
    end

    assign w_load    = i_cmd.hit_out | w_push;
    assign n_o_valid = w_load | (r_o_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_hit          <= i_cmd.hit_out;
            o_evicted      <= i_cmd.evict_commit;
            o_evicted_page <= i_cmd.evict_commit ? r_victim : '0;
            o_frame        <= i_cmd.hit_out ? r_pf_q : w_pf_wd;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_sts.resident = r_resident[r_page];
    assign o_sts.room     = GW'(r_count) < w_grant;
    assign o_sts.out_free = ~r_o_valid | i_out_ready;

endmodule

// File: sv/fifo_page_replacement.sv
// FIFO page replacement for one task, one result item per referenced page.
// Each item is taken in the idle state; a hit or a free-frame fault registers its
// result from the lookup state, a replacement from the lookup and evict states.
// A new item is taken only once the last one is done; the single-port
// page-frame table takes one access per cycle. Output register decouples sides.
// Reset (synchronous, active low): no page resident, FIFO head and count zero,
// frames_in_use 3, first_frame 2; no clearing pass, items accepted at once.
module fifo_page_replacement #(
    parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fpr_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [fpr_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [3:0] page_number
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,   // [8:0] frame_number, [12:9] evicted_page
    output logic [1:0]                m_axis_tuser    // [0] hit, [1] evicted
);

    fpr_pkg::t_cmd w_cmd;
    fpr_pkg::t_sts w_sts;

    logic                        w_hit;
    logic                        w_evicted;
    logic [fpr_pkg::FRAME_W-1:0] w_frame;
    logic [fpr_pkg::PAGE_W-1:0]  w_evicted_page;

    fpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fpr_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_page         (s_axis_tdata[fpr_pkg::PAGE_W-1:0]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_hit          (w_hit),
        .o_frame        (w_frame),
        .o_evicted      (w_evicted),
        .o_evicted_page (w_evicted_page)
    );

    assign m_axis_tdata = {3'b000, w_evicted_page, w_frame};
    assign m_axis_tuser = {w_evicted, w_hit};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |-> !(w_cmd.hit_out || w_cmd.free_commit || w_cmd.evict_commit))
        else $error("result loaded over an untaken item");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready
        |-> !(w_cmd.hit_out || w_cmd.free_commit || w_cmd.evict_read || w_cmd.evict_commit))
        else $error("table command issued while taking items");

    a_evict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.evict_read |=> !s_axis_tready)
        else $error("item taken during replacement");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
        else $error("hit reported with eviction");

endmodule

// File: tb/fifo_page_replacement_test.sv
`timescale 1ns / 1ps

module fifo_page_replacement_test;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic                        hit;
        logic [fpr_pkg::FRAME_W-1:0] frame_number;
        logic                        evicted;
        logic [fpr_pkg::PAGE_W-1:0]  evicted_page;
    } t_translation;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [fpr_pkg::IDX_W-1:0]   i_cfg_idx = '0;
    logic [fpr_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [15:0]                 m_axis_tdata;
    logic [1:0]                  m_axis_tuser;

    // page-table and FIFO state of the predictor
    logic [fpr_pkg::FIU_W-1:0]   frames_granted = fpr_pkg::FRAMES_IN_USE_RESET;
    logic [fpr_pkg::FRAME_W-1:0] base_frame = fpr_pkg::FIRST_FRAME_RESET;
    logic                        page_loaded [fpr_pkg::MAX_PAGES];
    logic [fpr_pkg::FRAME_W-1:0] frame_of_page [fpr_pkg::MAX_PAGES];
    logic [fpr_pkg::PAGE_W-1:0]  arrival_order [fpr_pkg::MAX_FRAMES];
    logic [2:0]                  oldest_slot = '0;
    logic [3:0]                  pages_held = '0;

    logic [fpr_pkg::PAGE_W-1:0]  page_refs_pending [$];
    t_translation                expected_translations [$];

    t_idle_mode         idle_mode = IDLE_NONE;
    logic               hold_arm = 1'b0;
    logic               hold_taken = 1'b0;
    int                 hold_left = 0;
    int                 error_count = 0;
    int                 hot_base = 0;

    fifo_page_replacement dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [3:0] page_number
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [8:0] frame_number, [12:9] evicted_page
        .m_axis_tuser  (m_axis_tuser)    // [0] hit, [1] evicted
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_translation translate_page(input logic [fpr_pkg::PAGE_W-1:0] page);
        t_translation res;
        logic [3:0]   grant;
        logic [fpr_pkg::PAGE_W-1:0] victim;
        res = '0;
        grant = frames_granted;
        if (grant == 4'd0) grant = 4'd1;
        if (grant > 4'(fpr_pkg::MAX_FRAMES)) grant = 4'(fpr_pkg::MAX_FRAMES);
        if (page_loaded[page]) begin
            res.hit = 1'b1;
            res.frame_number = frame_of_page[page];
        end else if (pages_held < grant) begin
            res.frame_number = fpr_pkg::FRAME_W'(base_frame + pages_held);
            frame_of_page[page] = res.frame_number;
            page_loaded[page] = 1'b1;
            arrival_order[3'(oldest_slot + pages_held)] = page;
            pages_held = pages_held + 1'b1;
        end else begin
            victim = arrival_order[oldest_slot];
            res.evicted = 1'b1;
            res.evicted_page = victim;
            res.frame_number = frame_of_page[victim];
            page_loaded[victim] = 1'b0;
            frame_of_page[page] = res.frame_number;
            page_loaded[page] = 1'b1;
            arrival_order[3'(oldest_slot + pages_held)] = page;
            oldest_slot = oldest_slot + 1'b1;
        end
        return res;
    endfunction

    function automatic logic sender_pauses();
        if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 46;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 18;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 46;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 18;
        return 1'b0;
    endfunction

    function automatic logic [fpr_pkg::PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 99) < 70)
            return fpr_pkg::PAGE_W'(hot_base + $urandom_range(0, 5));
        return fpr_pkg::PAGE_W'($urandom_range(0, fpr_pkg::MAX_PAGES - 1));
    endfunction

    task automatic check_translation(input t_translation got);
        t_translation want;
        if (expected_translations.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, actual %p", $time, got);
        end else begin
            want = expected_translations.pop_front();
            if (got.hit !== want.hit) begin
                error_count++;
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            end
            if (got.frame_number !== want.frame_number) begin
                error_count++;
                $display("%0t: frame_number expected %0d actual %0d",
                         $time, want.frame_number, got.frame_number);
            end
            if (got.evicted !== want.evicted) begin
                error_count++;
                $display("%0t: evicted expected %0b actual %0b",
                         $time, want.evicted, got.evicted);
            end
            if (got.evicted_page !== want.evicted_page) begin
                error_count++;
                $display("%0t: evicted_page expected %0d actual %0d",
                         $time, want.evicted_page, got.evicted_page);
            end
        end
    endtask

    // driver: advance to the next pending item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_translations.push_back(
                    translate_page(s_axis_tdata[fpr_pkg::PAGE_W-1:0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (page_refs_pending.size() != 0 && !sender_pauses()) begin
                    s_axis_tdata <= {4'b0, page_refs_pending.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, taken once
    always @(posedge i_clk) begin
        if (hold_arm && !hold_taken) begin
            hold_left <= 150;
            hold_taken <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_translation({m_axis_tuser[0], m_axis_tdata[8:0],
                                   m_axis_tuser[1], m_axis_tdata[12:9]});
            m_axis_tready <= (hold_left == 0) && !receiver_stalls();
        end
    end

    task automatic write_register(input logic [fpr_pkg::IDX_W-1:0] idx,
                                  input logic [fpr_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == fpr_pkg::REG_FRAMES_IN_USE) frames_granted = data[fpr_pkg::FIU_W-1:0];
        else if (idx == fpr_pkg::REG_FIRST_FRAME) base_frame = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (page_refs_pending.size() != 0 || s_axis_tvalid
               || expected_translations.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [fpr_pkg::CFG_W-1:0] grant_data,
                             input logic [fpr_pkg::CFG_W-1:0] base_data,
                             input t_idle_mode mode, input int count, input logic hold);
        write_register(fpr_pkg::REG_FRAMES_IN_USE, grant_data);
        write_register(fpr_pkg::REG_FIRST_FRAME, base_data);
        @(negedge i_clk);
        idle_mode = mode;
        hot_base = $urandom_range(0, fpr_pkg::MAX_PAGES - 1);
        if (hold) hold_arm = 1'b1;
        repeat (count) page_refs_pending.push_back(pick_page());
        wait_drained();
    endtask

    initial begin
        foreach (page_loaded[p]) begin
            page_loaded[p] = 1'b0;
            frame_of_page[p] = '0;
        end
        foreach (arrival_order[s]) arrival_order[s] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill three frames, hit, then evict page 0 and re-fetch it
        page_refs_pending = '{4'd0, 4'd15, 4'd0, 4'd7, 4'd15, 4'd5, 4'd0, 4'd3, 4'd8};
        wait_drained();
        // grant of zero with stray upper data bits, grant below the frames held
        write_register(fpr_pkg::REG_FRAMES_IN_USE, 9'h1F0);
        write_register(fpr_pkg::REG_FIRST_FRAME, 9'h000);
        @(negedge i_clk);
        page_refs_pending = '{4'd8, 4'd1, 4'd1, 4'd14};
        wait_drained();
        // frame index wraps past the end of memory
        write_register(fpr_pkg::REG_FRAMES_IN_USE, 9'h004);
        write_register(fpr_pkg::REG_FIRST_FRAME, 9'h1FF);
        @(negedge i_clk);
        page_refs_pending = '{4'd6, 4'd6, 4'd2};
        wait_drained();

        run_phase(9'h0FF, 9'd509, IDLE_NONE, 165, 1'b1);
        run_phase(9'd8, 9'd0, IDLE_SENDER, 165, 1'b0);
        run_phase(9'd1, 9'd511, IDLE_RECEIVER, 165, 1'b0);
        run_phase(9'h1E5, 9'd100, IDLE_BOTH, 165, 1'b0);
        run_phase(9'd0, 9'd256, IDLE_NONE, 165, 1'b0);
        run_phase(9'd15, 9'd3, IDLE_SENDER, 165, 1'b0);
        run_phase(9'd8, 9'd504, IDLE_RECEIVER, 165, 1'b0);
        run_phase(9'd2, 9'd0, IDLE_BOTH, 165, 1'b0);
        run_phase(fpr_pkg::CFG_W'($urandom), fpr_pkg::CFG_W'($urandom), IDLE_BOTH, 165, 1'b0);
        run_phase(fpr_pkg::CFG_W'($urandom), fpr_pkg::CFG_W'($urandom), IDLE_NONE, 165, 1'b0);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
